### sv/vector_angle_degrees_core_macros.svh
// Assertion macros shared by the vector angle core.
`ifndef VECTOR_ANGLE_DEGREES_CORE_MACROS_SVH
`define VECTOR_ANGLE_DEGREES_CORE_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define VAD_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define VAD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/vad_pkg.sv
package vad_pkg;

   // Rotation count and datapath widths of the CORDIC chain.
   localparam int CORDIC_STEPS = 32;
   localparam int XY_W         = 63;
   localparam int Z_W          = 42;
   localparam int A_W          = 42;
   localparam int NORM_MSB     = 59;
   localparam int SHIFT_W      = 6;
   localparam int FRAC_Z       = 32;

   // Fixed angles in units of 2^-32 degree.
   localparam logic [A_W-1:0] DEG90_Z  = A_W'(64'd90 << FRAC_Z);
   localparam logic [A_W-1:0] DEG180_Z = A_W'(64'd180 << FRAC_Z);
   localparam logic [A_W-1:0] DEG360_Z = A_W'(64'd360 << FRAC_Z);

   // How the result of one item is formed.
   typedef enum logic [2:0] {
      DIR_CORDIC = 3'd0,
      DIR_UP     = 3'd1,
      DIR_DOWN   = 3'd2,
      DIR_RIGHT  = 3'd3,
      DIR_LEFT   = 3'd4
   } dir_type;

   // Sideband that travels with each item along the chain.
   typedef struct packed {
      dir_type dir;
      logic    dx_neg;
      logic    dy_neg;
   } tag_type;

   // Working vector of one CORDIC cell.
   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
   } vec_type;

   // Shift-subtract quotient, evaluated only while building constants.
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] r;
      logic [63:0] q;
      int b;
      r = '0;
      q = '0;
      for (b = 63; b >= 0; b--) begin
         r = {r[63:0], num[b]};
         if (r >= {1'b0, den}) begin
            r = r - {1'b0, den};
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // Arctangent of 1/n in Q60 by the truncated alternating series.
   function automatic logic [63:0] atan_recip(input logic [63:0] n);
      logic [63:0] nsq;
      logic [63:0] p;
      logic [63:0] sum;
      logic [63:0] t;
      int k;
      nsq = n * n;
      p   = udiv64(64'd1 << 60, n);
      sum = '0;
      for (k = 0; k < 64; k++) begin
         if (p != 64'd0) begin
            t = udiv64(p, 64'(2 * k + 1));
            if (k % 2 == 1) begin
               sum = sum - t;
            end else begin
               sum = sum + t;
            end
            p = udiv64(p, nsq);
         end
      end
      return sum;
   endfunction

   // Arctangent table entry of rotation idx, in units of 2^-32 degree.
   function automatic logic [63:0] atan_entry(input int idx);
      logic [63:0] qpi;
      logic [63:0] a;
      logic [63:0] rem;
      logic [63:0] q;
      int b;
      qpi = (atan_recip(64'd5) << 2) - atan_recip(64'd239);
      a   = (idx == 0) ? qpi : atan_recip(64'd1 << idx);
      rem = a;
      q   = '0;
      if (rem >= qpi) begin
         q   = 64'd1;
         rem = rem - qpi;
      end
      for (b = 0; b < 40; b++) begin
         rem = rem << 1;
         q   = q << 1;
         if (rem >= qpi) begin
            rem  = rem - qpi;
            q[0] = 1'b1;
         end
      end
      return (q * 64'd45 + 64'd128) >> 8;
   endfunction

endpackage

### sv/vector_angle_degrees_core.sv
// Channel | Direction | Transfer contents
// req_    | in        | tdata: point_x, point_y, center_x, center_y (COORD_WIDTH bits each)
// rsp_    | out       | tdata: angle (9 + ANGLE_FRAC_BITS bits, 1/2^F degree)
//
// One transfer is accepted per cycle while the chain is not stalled; each result
// passes through three front stages, 32 rotation cells, one fold stage and
// the output register.
// Reset is synchronous and clears all valid bits; payload is not reset.
// While rsp_tready is low with a result pending, the whole chain holds and
// one further request is kept in an input skid register.
`include "vector_angle_degrees_core_macros.svh"

module vector_angle_degrees_core #(
   parameter int COORD_WIDTH     = 16,
   parameter int ANGLE_FRAC_BITS = 8
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_tvalid,
   output logic                                       req_tready,
   // point_x, point_y, center_x, center_y from the lowest bit up
   input  logic [((4*COORD_WIDTH+7)/8)*8-1:0]         req_tdata,
   output logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   // angle from the lowest bit up
   output logic [((9+ANGLE_FRAC_BITS+7)/8)*8-1:0]     rsp_tdata
);
   import vad_pkg::*;

   localparam int IN_W        = 4 * COORD_WIDTH;
   localparam int ANGLE_W     = 9 + ANGLE_FRAC_BITS;
   localparam int OUT_TDATA_W = ((ANGLE_W + 7) / 8) * 8;
   localparam logic [A_W-1:0]     ROUND_HALF = A_W'(64'd1 << (31 - ANGLE_FRAC_BITS));
   localparam logic [ANGLE_W-1:0] ANG_90     = ANGLE_W'(64'd90 << ANGLE_FRAC_BITS);
   localparam logic [ANGLE_W-1:0] ANG_180    = ANGLE_W'(64'd180 << ANGLE_FRAC_BITS);
   localparam logic [ANGLE_W-1:0] ANG_270    = ANGLE_W'(64'd270 << ANGLE_FRAC_BITS);
   localparam logic [ANGLE_W-1:0] ANG_360    = ANGLE_W'(64'd360 << ANGLE_FRAC_BITS);

   logic                  advance, in_fire, src_valid;
   logic [IN_W-1:0]       src_data, skid_data_in, skid_data_ff;
   logic                  skid_full_in, skid_full_ff;

   logic                  chain_valid [CORDIC_STEPS+1];
   vec_type               chain_vec   [CORDIC_STEPS+1];
   tag_type               chain_tag   [CORDIC_STEPS+1];

   logic [A_W-1:0]        phi, back_a_in, back_a_ff, round_sum;
   tag_type               back_tag_ff;
   logic                  back_valid_ff;
   logic [ANGLE_W-1:0]    rounded, wrapped, angle_in, angle_ff;
   logic                  rsp_valid_ff;

   // The chain moves whenever the output register is free or being drained.
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !skid_full_ff;
   assign in_fire    = req_tvalid && req_tready;

   // Input skid: hold one transfer while the chain is stalled.
   always_comb begin
      skid_full_in = skid_full_ff;
      skid_data_in = skid_data_ff;
      if (advance) begin
         skid_full_in = 1'b0;
      end else if (in_fire) begin
         skid_full_in = 1'b1;
         skid_data_in = req_tdata[IN_W-1:0];
      end
   end

   assign src_valid = skid_full_ff || in_fire;
   assign src_data  = skid_full_ff ? skid_data_ff : req_tdata[IN_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_full_ff <= 1'b0;
      end else begin
         skid_full_ff <= skid_full_in;
      end
   end

   always_ff @(posedge clock) begin
      skid_data_ff <= skid_data_in;
   end

   // Differences, magnitudes and normalization.
   vad_front #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (src_valid),
      .point_x  (src_data[0 +: COORD_WIDTH]),
      .point_y  (src_data[COORD_WIDTH +: COORD_WIDTH]),
      .center_x (src_data[2*COORD_WIDTH +: COORD_WIDTH]),
      .center_y (src_data[3*COORD_WIDTH +: COORD_WIDTH]),
      .out_valid(chain_valid[0]),
      .out_vec  (chain_vec[0]),
      .out_tag  (chain_tag[0])
   );

   // Row of rotation cells, one per CORDIC iteration.
   for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
      vad_cell #(
         .STAGE(g)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .in_valid (chain_valid[g]),
         .in_vec   (chain_vec[g]),
         .in_tag   (chain_tag[g]),
         .out_valid(chain_valid[g+1]),
         .out_vec  (chain_vec[g+1]),
         .out_tag  (chain_tag[g+1])
      );
   end

   // Clamp to the first quadrant, then fold into the full circle.
   always_comb begin
      if (chain_vec[CORDIC_STEPS].z[Z_W-1]) begin
         phi = '0;
      end else if (A_W'($unsigned(chain_vec[CORDIC_STEPS].z)) > DEG90_Z) begin
         phi = DEG90_Z;
      end else begin
         phi = A_W'($unsigned(chain_vec[CORDIC_STEPS].z));
      end
      unique case ({chain_tag[CORDIC_STEPS].dx_neg, chain_tag[CORDIC_STEPS].dy_neg})
         2'b00: back_a_in = phi;
         2'b10: back_a_in = DEG180_Z - phi;
         2'b11: back_a_in = DEG180_Z + phi;
         2'b01: back_a_in = DEG360_Z - phi;
         default: back_a_in = phi;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         back_valid_ff <= 1'b0;
      end else if (advance) begin
         back_valid_ff <= chain_valid[CORDIC_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         back_a_ff   <= back_a_in;
         back_tag_ff <= chain_tag[CORDIC_STEPS];
      end
   end

   // Round half up to the output precision, wrap a full turn to zero; axis cases get fixed angles.
   always_comb begin
      round_sum = back_a_ff + ROUND_HALF;
      rounded   = round_sum[FRAC_Z-ANGLE_FRAC_BITS +: ANGLE_W];
      wrapped   = (rounded >= ANG_360) ? rounded - ANG_360 : rounded;
      unique case (back_tag_ff.dir)
         DIR_CORDIC: angle_in = wrapped;
         DIR_UP:     angle_in = ANG_270;
         DIR_DOWN:   angle_in = ANG_90;
         DIR_RIGHT:  angle_in = '0;
         DIR_LEFT:   angle_in = ANG_180;
         default:    angle_in = '0;
      endcase
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= back_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         angle_ff <= angle_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = OUT_TDATA_W'(angle_ff);

   // A delivered angle is always below a full turn.
   `VAD_ASSERT_IMPLIES(a_angle_range, clock, reset, rsp_valid_ff, angle_ff < ANG_360, "angle reached a full turn")
   // A held request stays put until the chain moves.
   `VAD_ASSERT_NEXT(a_skid_hold, clock, reset, skid_full_ff && !advance, skid_full_ff && $stable(skid_data_ff), "skid register lost its transfer")
   // A vertical upward direction leaves the output as exactly 270 degrees.
   `VAD_ASSERT_NEXT(a_vertical_up, clock, reset, advance && back_valid_ff && back_tag_ff.dir == DIR_UP, rsp_valid_ff && angle_ff == ANG_270, "vertical case not 270 degrees")
   // A stall freezes the fold stage occupancy.
   `VAD_ASSERT_NEXT(a_stall_freeze, clock, reset, !advance, $stable(back_valid_ff) && rsp_valid_ff, "chain moved during a stall")

endmodule

### sv/vad_front.sv
module vad_front #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          in_valid,
   input  logic signed [COORD_WIDTH-1:0] point_x,
   input  logic signed [COORD_WIDTH-1:0] point_y,
   input  logic signed [COORD_WIDTH-1:0] center_x,
   input  logic signed [COORD_WIDTH-1:0] center_y,
   output logic                          out_valid,
   output vad_pkg::vec_type              out_vec,
   output vad_pkg::tag_type              out_tag
);
   import vad_pkg::*;

   localparam int MSB_W = (COORD_WIDTH > 1) ? $clog2(COORD_WIDTH) : 1;

   logic signed [COORD_WIDTH:0] dx_in, dx_ff, dy_in, dy_ff;
   logic [COORD_WIDTH-1:0]      ax_in, ax_ff, ay_in, ay_ff, big;
   logic [MSB_W-1:0]            msb;
   logic [SHIFT_W-1:0]          shift_in, shift_ff;
   tag_type                     tag1_in, tag1_ff, tag2_ff;
   vec_type                     vec_in, vec_ff;
   logic                        v0_ff, v1_ff, v2_ff;

   // First stage: differences to the center, one bit wider than a coordinate.
   assign dx_in = {point_x[COORD_WIDTH-1], point_x} - {center_x[COORD_WIDTH-1], center_x};
   assign dy_in = {point_y[COORD_WIDTH-1], point_y} - {center_y[COORD_WIDTH-1], center_y};

   // Second stage: magnitudes, axis cases and the normalizing shift.
   always_comb begin
      ax_in = COORD_WIDTH'(dx_ff[COORD_WIDTH] ? -dx_ff : dx_ff);
      ay_in = COORD_WIDTH'(dy_ff[COORD_WIDTH] ? -dy_ff : dy_ff);
      big   = (ax_in > ay_in) ? ax_in : ay_in;
      msb   = '0;
      for (int b = 0; b < COORD_WIDTH; b++) begin
         if (big[b]) begin
            msb = MSB_W'(b);
         end
      end
      shift_in = SHIFT_W'(NORM_MSB) - SHIFT_W'(msb);
      tag1_in.dx_neg = dx_ff[COORD_WIDTH];
      tag1_in.dy_neg = dy_ff[COORD_WIDTH];
      priority if (dx_ff == '0) begin
         tag1_in.dir = (dy_ff[COORD_WIDTH] || dy_ff == '0) ? DIR_UP : DIR_DOWN;
      end else if (dy_ff == '0) begin
         tag1_in.dir = dx_ff[COORD_WIDTH] ? DIR_LEFT : DIR_RIGHT;
      end else begin
         tag1_in.dir = DIR_CORDIC;
      end
   end

   // Third stage: place the larger magnitude's top bit at the working MSB.
   always_comb begin
      vec_in.x = $signed(XY_W'(ax_ff) << shift_ff);
      vec_in.y = $signed(XY_W'(ay_ff) << shift_ff);
      vec_in.z = '0;
   end

   // Stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (advance) begin
         v0_ff <= in_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
      end
   end

   // Stage payload.
   always_ff @(posedge clock) begin
      if (advance) begin
         dx_ff    <= dx_in;
         dy_ff    <= dy_in;
         ax_ff    <= ax_in;
         ay_ff    <= ay_in;
         shift_ff <= shift_in;
         tag1_ff  <= tag1_in;
         tag2_ff  <= tag1_ff;
         vec_ff   <= vec_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_vec   = vec_ff;
   assign out_tag   = tag2_ff;

endmodule

### sv/vad_cell.sv
module vad_cell #(
   parameter int STAGE = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             in_valid,
   input  vad_pkg::vec_type in_vec,
   input  vad_pkg::tag_type in_tag,
   output logic             out_valid,
   output vad_pkg::vec_type out_vec,
   output vad_pkg::tag_type out_tag
);
   import vad_pkg::*;

   localparam logic [63:0]           ATAN_WORD = atan_entry(STAGE);
   localparam logic signed [Z_W-1:0] ATAN_Z    = ATAN_WORD[Z_W-1:0];

   logic signed [XY_W-1:0] xs, ys;
   vec_type                vec_in, vec_ff;
   tag_type                tag_ff;
   logic                   valid_ff;

   // One vectoring rotation: drive y toward zero, accumulate the angle.
   always_comb begin
      xs = in_vec.x >>> STAGE;
      ys = in_vec.y >>> STAGE;
      if (!in_vec.y[XY_W-1]) begin
         vec_in.x = in_vec.x + ys;
         vec_in.y = in_vec.y - xs;
         vec_in.z = in_vec.z + ATAN_Z;
      end else begin
         vec_in.x = in_vec.x - ys;
         vec_in.y = in_vec.y + xs;
         vec_in.z = in_vec.z - ATAN_Z;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         vec_ff <= vec_in;
         tag_ff <= in_tag;
      end
   end

   assign out_valid = valid_ff;
   assign out_vec   = vec_ff;
   assign out_tag   = tag_ff;

endmodule

### tb/vector_angle_degrees_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the vector angle core. Every request transfer is
// turned into the expected angle by a bit-exact CORDIC predictor, and every
// response transfer is compared against the oldest expected angle.
module vector_angle_degrees_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   // point_x, point_y, center_x, center_y from the lowest bit up
   input  logic [63:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   // angle from the lowest bit up
   input  logic [23:0] rsp_tdata,
   output int          mismatch_count,
   output int          outstanding
);

   localparam int ROTATIONS = 32;
   localparam int FRAC      = 8;

   // Arctangent of each rotation, in units of 2^-32 degree.
   longint      step_angle [ROTATIONS];
   // Angles still owed by the core, oldest first.
   logic [16:0] expected_angles [$];
   int          errors = 0;

   // Arctangent of 1/n in Q60 from the alternating power series.
   function automatic longint unsigned arctan_inv(input longint unsigned n);
      longint unsigned n_squared;
      longint unsigned power;
      longint unsigned acc;
      longint unsigned k;
      n_squared = n * n;
      power     = (64'd1 << 60) / n;
      acc       = 0;
      k         = 0;
      while (power != 0) begin
         if (k[0]) begin
            acc = acc - power / (2 * k + 1);
         end else begin
            acc = acc + power / (2 * k + 1);
         end
         power = power / n_squared;
         k     = k + 1;
      end
      return acc;
   endfunction

   // Build the rotation table: each arctangent scaled from Q60 radians
   // (relative to pi/4) into 2^-32 degree units, rounded to nearest.
   initial begin : build_table
      longint unsigned quarter_pi;
      longint unsigned rot;
      logic [127:0]    ratio;
      quarter_pi = 4 * arctan_inv(64'd5) - arctan_inv(64'd239);
      for (int i = 0; i < ROTATIONS; i++) begin
         rot           = (i == 0) ? quarter_pi : arctan_inv(64'd1 << i);
         ratio         = ({64'd0, rot} << 40) / {64'd0, quarter_pi};
         step_angle[i] = longint'((ratio[63:0] * 45 + 128) >> 8);
      end
   end

   // Clockwise direction from center to point in 1/256 degree.
   function automatic logic [16:0] direction_degrees(input logic [63:0] coords);
      logic signed [15:0] px;
      logic signed [15:0] py;
      logic signed [15:0] cx;
      logic signed [15:0] cy;
      longint             dx;
      longint             dy;
      longint             ax;
      longint             ay;
      longint             span;
      longint             x;
      longint             y;
      longint             z;
      longint             xs;
      longint             ys;
      longint             turn;
      longint             rounded;
      int                 shift;
      px = coords[15:0];
      py = coords[31:16];
      cx = coords[47:32];
      cy = coords[63:48];
      dx = px - cx;
      dy = py - cy;

      // Points on the axes through the center get fixed angles.
      if (dx == 0) begin
         rounded = (dy <= 0) ? (64'sd270 <<< FRAC) : (64'sd90 <<< FRAC);
      end else if (dy == 0) begin
         rounded = (dx > 0) ? 64'sd0 : (64'sd180 <<< FRAC);
      end else begin
         ax    = (dx < 0) ? -dx : dx;
         ay    = (dy < 0) ? -dy : dy;
         span  = (ax > ay) ? ax : ay;
         shift = 0;
         while ((span <<< shift) < (64'sd1 <<< 59)) begin
            shift++;
         end
         x = ax <<< shift;
         y = ay <<< shift;
         z = 0;

         // Vectoring rotations drive y toward zero.
         for (int i = 0; i < ROTATIONS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
               x = x + ys;
               y = y - xs;
               z = z + step_angle[i];
            end else begin
               x = x - ys;
               y = y + xs;
               z = z - step_angle[i];
            end
         end
         if (z < 0) begin
            z = 0;
         end
         if (z > (64'sd90 <<< 32)) begin
            z = 64'sd90 <<< 32;
         end

         // Fold the first-quadrant angle into the proper quadrant.
         if (dx > 0 && dy > 0) begin
            turn = z;
         end else if (dx < 0 && dy > 0) begin
            turn = (64'sd180 <<< 32) - z;
         end else if (dx < 0) begin
            turn = (64'sd180 <<< 32) + z;
         end else begin
            turn = (64'sd360 <<< 32) - z;
         end

         // Round half up to the output resolution, wrapping 360 to 0.
         rounded = (turn + (64'sd1 <<< (31 - FRAC))) >>> (32 - FRAC);
         if (rounded >= (64'sd360 <<< FRAC)) begin
            rounded = rounded - (64'sd360 <<< FRAC);
         end
      end
      return rounded[16:0];
   endfunction

   // Retire responses before queueing new requests, so a response can never
   // be matched against a request accepted at the same edge.
   always @(posedge clock) begin : watch_channels
      logic [16:0] want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_angles.size() == 0) begin
               $error("rsp transfer with no angle expected: angle %0d", rsp_tdata[16:0]);
               errors++;
            end else begin
               want = expected_angles.pop_front();
               if (rsp_tdata[16:0] !== want) begin
                  $error("angle mismatch: expected %0d, actual %0d", want, rsp_tdata[16:0]);
                  errors++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            expected_angles.push_back(direction_degrees(req_tdata));
         end
      end
      mismatch_count <= errors;
      outstanding    <= expected_angles.size();
   end

endmodule

### tb/vector_angle_degrees_core_tb.sv
`timescale 1ns / 100ps

// Drives point and center pairs into the vector angle core with random
// idling on both channels and reports the verdict from the checker.
module vector_angle_degrees_core_tb;

   localparam int QUIET_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 50;
   localparam int PHASE_ITEMS  = 344;

   // Coordinates at and next to the ends of the signed 16-bit range, and around zero.
   localparam logic [15:0] EDGE_VALUES [6] = '{
      16'h8000, 16'h8001, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFF
   };

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   // point_x, point_y, center_x, center_y from the lowest bit up
   logic [63:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   // angle from the lowest bit up
   logic [23:0] rsp_tdata;
   int          mismatch_count;
   int          outstanding;
   int          send_idle_pct;
   int          recv_idle_pct;
   int          quiet_cycles = 0;

   vector_angle_degrees_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   vector_angle_degrees_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver backpressure.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog: too long without any transfer ends the run.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Offer one transfer, with random idle cycles ahead of it. Ready is
   // sampled at the falling edge, where it is settled for the coming edge.
   task automatic send_pair(input logic [15:0] px, input logic [15:0] py,
                            input logic [15:0] cx, input logic [15:0] cy);
      logic taken;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= {$urandom, $urandom};
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {cy, cx, py, px};
      do begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end while (!taken);
   endtask

   // Random pair, biased toward axes, diagonals, range ends and tiny offsets.
   task automatic send_random_pair();
      logic [15:0] px;
      logic [15:0] py;
      logic [15:0] cx;
      logic [15:0] cy;
      logic [15:0] d;
      px = $urandom;
      py = $urandom;
      cx = $urandom;
      cy = $urandom;
      d  = $urandom;
      case ($urandom_range(9))
         4, 5: begin
            px = cx + 16'($urandom_range(16)) - 16'd8;
            py = cy + 16'($urandom_range(16)) - 16'd8;
         end
         6: begin
            if ($urandom_range(1)) begin
               px = cx;
            end else begin
               py = cy;
            end
         end
         7: begin
            px = cx + d;
            py = $urandom_range(1) ? cy + d : cy - d;
         end
         8: begin
            px = EDGE_VALUES[$urandom_range(5)];
            py = EDGE_VALUES[$urandom_range(5)];
            cx = EDGE_VALUES[$urandom_range(5)];
            cy = EDGE_VALUES[$urandom_range(5)];
         end
         9: begin
            // Just off an axis, where rounding and the wrap at 360 matter.
            if ($urandom_range(1)) begin
               py = cy + 16'($urandom_range(2)) - 16'd1;
            end else begin
               px = cx + 16'($urandom_range(2)) - 16'd1;
            end
         end
         default: ;
      endcase
      send_pair(px, py, cx, cy);
   endtask

   // Let every expected angle come back before going on.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) begin
         @(posedge clock);
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed pairs: axes, coincident points, quadrants, range ends.
      send_idle_pct = 8;
      recv_idle_pct = 66;
      send_pair(16'd5, 16'd5, 16'd5, 16'd5);
      send_pair(16'd0, 16'd100, 16'd0, 16'd0);
      send_pair(16'd0, -16'd100, 16'd0, 16'd0);
      send_pair(16'd100, 16'd0, 16'd0, 16'd0);
      send_pair(-16'd100, 16'd0, 16'd0, 16'd0);
      send_pair(16'd3, 16'd4, 16'd0, 16'd0);
      send_pair(-16'd3, 16'd4, 16'd0, 16'd0);
      send_pair(-16'd3, -16'd4, 16'd0, 16'd0);
      send_pair(16'd3, -16'd4, 16'd0, 16'd0);
      send_pair(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000);
      send_pair(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
      send_pair(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
      send_pair(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
      send_pair(16'h7FFF, 16'hFFFF, 16'h8000, 16'h0000);
      send_pair(16'h7FFF, 16'h0001, 16'h8000, 16'h0000);
      send_pair(16'h8000, 16'h0001, 16'h7FFF, 16'h0000);
      send_pair(16'h8000, 16'hFFFF, 16'h7FFF, 16'h0000);
      send_pair(16'h0001, 16'h7FFF, 16'h0000, 16'h8000);
      send_pair(16'h0001, 16'h8000, 16'h0000, 16'h7FFF);
      send_pair(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000);
      send_pair(16'h8000, 16'h8000, 16'h7FFF, 16'h8000);

      // Random pairs under three idling mixes.
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 8;
               recv_idle_pct = 66;
            end
            1: begin
               send_idle_pct = 66;
               recv_idle_pct = 8;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         repeat (PHASE_ITEMS) send_random_pair();
         drain();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
